/* hw/rtl/mph_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mph_pkg
// Shared types and constants for the modular polynomial string hash block.
// ----------------------------------------------------------------------------
package mph_pkg;

    localparam int DATA_W    = 32;
    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 2'd2;

    localparam logic              MODE_ZERO         = 1'b0;
    localparam logic              MODE_POLY         = 1'b1;
    localparam logic              RESET_HASH_MODE   = MODE_POLY;
    localparam logic [DATA_W-1:0] RESET_TABLE_SIZE  = 32'd1;
    localparam logic [DATA_W-1:0] RESET_MULTIPLIER  = 32'd1;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic mul;
        logic add;
        logic div_start;
        logic hash_from_sum;
        logic hash_from_rem;
        logic load_out;
    } mph_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic has_byte;
        logic is_last;
        logic mode;
        logic tsize_zero;
        logic div_done;
        logic out_full;
    } mph_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/mph_char_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mph_char_if
// Character item channel: one key character per item.
// ----------------------------------------------------------------------------
interface mph_char_if;
    import mph_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;
    logic              has_byte;
    logic              is_last;

    modport source (output valid, output char_byte, output has_byte, output is_last,
                    input ready);
    modport sink   (input valid, input char_byte, input has_byte, input is_last,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/mph_hash_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mph_hash_if
// Result item channel: finished slot index of one string.
// ----------------------------------------------------------------------------
interface mph_hash_if;
    import mph_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mph_cfg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mph_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mph_cfg_if;
    import mph_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] addr;
    logic [DATA_W-1:0]    wdata;

    modport source (output valid, output addr, output wdata, input ready);
    modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mph_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mph_div
// Restoring radix-2 divider, one quotient bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module mph_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [mph_pkg::DATA_W-1:0] dividend,
    input  wire logic [mph_pkg::DATA_W-1:0] divisor,
    output logic                           done,
    output logic [mph_pkg::DATA_W-1:0]     remainder
);
    import mph_pkg::*;

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [DATA_W-1:0]    dvd_reg,   dvd_next;
    logic [DATA_W-1:0]    dsr_reg,   dsr_next;
    logic [DATA_W-1:0]    rem_reg,   rem_next;
    logic [DATA_W:0]      trial;

    // shift in the next dividend bit and subtract when it fits
    assign trial = {rem_reg, dvd_reg[DATA_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DATA_W - 1);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DATA_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[DATA_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a finished run");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dsr_reg))
        else $error("remainder not below divisor");

endmodule

`default_nettype wire

/* hw/rtl/mph_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mph_dp
// Datapath: configuration registers, item registers, multiply, add, divider
// and the result register.
// ----------------------------------------------------------------------------
module mph_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mph_pkg::mph_cmd_t            cmd,
    output mph_pkg::mph_sts_t                 sts,
    input  wire logic [mph_pkg::CHAR_W-1:0]   char_byte,
    input  wire logic                         has_byte,
    input  wire logic                         is_last,
    input  wire logic                         cfg_we,
    input  wire logic [mph_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [mph_pkg::DATA_W-1:0]   cfg_wdata,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [mph_pkg::DATA_W-1:0]        out_hash
);
    import mph_pkg::*;

    logic              mode_reg;
    logic [DATA_W-1:0] tsize_reg;
    logic [DATA_W-1:0] mult_reg;

    logic [CHAR_W-1:0] byte_reg;
    logic              has_reg;
    logic              last_reg;
    logic              item_mode_reg;

    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] sum_reg;
    logic [DATA_W-1:0] hash_reg, hash_next;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_hash_reg;

    logic [DATA_W-1:0]   div_rem;
    logic                div_done;
    logic [2*DATA_W-1:0] prod_full;

    assign prod_full = hash_reg * mult_reg;

    mph_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (sum_reg),
        .divisor   (tsize_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= RESET_HASH_MODE;
            tsize_reg <= RESET_TABLE_SIZE;
            mult_reg  <= RESET_MULTIPLIER;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_HASH_MODE:  mode_reg  <= cfg_wdata[0];
                REG_TABLE_SIZE: tsize_reg <= cfg_wdata;
                REG_MULTIPLIER: mult_reg  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        hash_next = hash_reg;
        if (cmd.hash_from_sum)
        begin
            hash_next = sum_reg;
        end
        else if (cmd.hash_from_rem)
        begin
            hash_next = div_rem;
        end
        else if (cmd.load_out)
        begin
            hash_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_reg       <= 1'b0;
            last_reg      <= 1'b0;
            item_mode_reg <= MODE_POLY;
            hash_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                has_reg       <= has_byte;
                last_reg      <= is_last;
                item_mode_reg <= mode_reg;
            end
            hash_reg <= hash_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            byte_reg <= char_byte;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full[DATA_W-1:0];
        end
        // sign-extended character, wraps at the word width
        if (cmd.add)
        begin
            sum_reg <= prod_reg + {{(DATA_W-CHAR_W){byte_reg[CHAR_W-1]}}, byte_reg};
        end
        if (cmd.load_out)
        begin
            out_hash_reg <= (item_mode_reg == MODE_POLY) ? hash_reg : '0;
        end
    end

    always_comb
    begin
        sts.has_byte   = has_reg;
        sts.is_last    = last_reg;
        sts.mode       = item_mode_reg;
        sts.tsize_zero = (tsize_reg == '0);
        sts.div_done   = div_done;
        sts.out_full   = out_valid_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_hash  = out_hash_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_valid_reg)
        else $error("result register overwritten");

    a_hash_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hash_from_rem |=> (hash_reg < $past(tsize_reg)))
        else $error("running hash not reduced");

    a_mode_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out && (item_mode_reg == MODE_ZERO) |=> (out_hash_reg == '0))
        else $error("nonzero hash in mode zero");

    a_hash_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (hash_reg == '0))
        else $error("running hash not cleared after a string");

endmodule

`default_nettype wire

/* hw/rtl/mph_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mph_ctrl
// Controller: sequences item load, multiply, add, reduction and result.
// ----------------------------------------------------------------------------
module mph_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output mph_pkg::mph_cmd_t       cmd,
    input  wire mph_pkg::mph_sts_t  sts
);
    import mph_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_ADD,
        ST_REDUCE,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.has_byte && (sts.mode == MODE_POLY))
                begin
                    state_next = ST_MUL;
                end
                else if (sts.is_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                // zero table size keeps the wrapped sum
                if (sts.tsize_zero)
                begin
                    cmd.hash_from_sum = 1'b1;
                    state_next        = sts.is_last ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.hash_from_rem = 1'b1;
                    state_next        = sts.is_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!sts.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_start_then_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == ST_DIV) && !sts.div_done)
        else $error("divide sequence broken");

    a_emit_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.is_last)
        else $error("result for an item that does not end a string");

endmodule

`default_nettype wire

/* hw/rtl/modular_polynomial_string_hash.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// modular_polynomial_string_hash
// Polynomial rolling hash of a key string into a table slot, one character
// per item, reduced modulo a nonzero table size after every character in mode 1.
// ----------------------------------------------------------------------------
//  channel   dir   payload                           transfer
//  chars     in    char_byte[7:0] has_byte is_last   valid && ready
//  hashes    out   hash_value[31:0]                  valid && ready
//  cfg       in    addr[1:0] wdata[31:0]             valid && ready (always ready)
//
//  one item at a time: a character in mode 1 waits for the 32-step
//  bit-serial divider before the next accept; a zero table size skips the
//  divider, and other items skip the multiply, add and divider.
//  an item that ends a string then loads the result register in the emit state.
//  no clearing pass after reset; the result register lets the next item in
//  while a result waits, a stalled result holds only the next string end.
// ----------------------------------------------------------------------------
module modular_polynomial_string_hash (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mph_char_if.sink   chars,
    mph_hash_if.source hashes,
    mph_cfg_if.sink    cfg
);
    import mph_pkg::*;

    mph_cmd_t cmd;
    mph_sts_t sts;
    logic     in_ready;

    mph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mph_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .char_byte (chars.char_byte),
        .has_byte  (chars.has_byte),
        .is_last   (chars.is_last),
        .cfg_we    (cfg.valid),
        .cfg_addr  (cfg.addr),
        .cfg_wdata (cfg.wdata),
        .out_valid (hashes.valid),
        .out_ready (hashes.ready),
        .out_hash  (hashes.hash_value)
    );

    assign chars.ready = in_ready;
    assign cfg.ready   = 1'b1;

endmodule

`default_nettype wire
